// ----- hdl/tophr_pkg.sv -----
// Shared types, constants and the quarter-wave cosine ROM contents for the
// time-offset phase ramp generator. No dependencies.
`timescale 1ns / 1ps

package tophr_pkg;

    // Largest FFT size and the widths that follow from it
    localparam int FFT_MAX     = 4096;
    localparam int PH_W        = $clog2(FFT_MAX);     // phase accumulator width
    localparam int LOG2_MAX    = PH_W;                // largest usable fft_log2
    localparam int LOG2_MIN    = 6;
    localparam int QUARTER     = FFT_MAX / 4;
    localparam int HALF_CIRCLE = FFT_MAX / 2;
    localparam int RA_W        = PH_W - 1;            // ROM address, 0..QUARTER

    // Configuration register map (word index = paddr[3:2])
    localparam int PADDR_W = 4;
    localparam logic [1:0] REG_FFT_LOG2 = 2'd0;
    localparam logic [1:0] REG_CP_SPAN  = 2'd1;
    localparam logic [1:0] REG_SC_COUNT = 2'd2;

    localparam int FFT_LOG2_RESET = 12;
    localparam int CP_SPAN_RESET  = 288;
    localparam int SC_COUNT_RESET = 3276;

    // State after reset: first entry of the table under the reset configuration
    localparam logic signed [10:0] OFFSET_RESET = 11'(0 - CP_SPAN_RESET);
    localparam logic [PH_W-1:0] PHASE_RESET =
        PH_W'(((FFT_MAX - SC_COUNT_RESET / 2) * (FFT_MAX - CP_SPAN_RESET)) % FFT_MAX);

    // Output FIFO between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Effective configuration, derived from the raw registers
    typedef struct packed {
        logic [9:0]      cp_span;
        logic [12:0]     count;       // subcarriers per row, 1..N
        logic [PH_W-1:0] neg_half;    // -(count/2) mod 2^PH_W
        logic [PH_W-1:0] phase_mask;  // N-1
        logic [2:0]      idx_shift;   // log2(FFT_MAX/N)
    } cfg_t;

    // One classified table entry waiting for the ROM lookup
    typedef struct packed {
        logic [PH_W-1:0]   phase;
        logic signed [10:0] offset;
        logic [11:0]       subcarrier;
        logic              table_end;
    } entry_t;

    typedef logic [15:0] rom_t [0:QUARTER];

    localparam logic [63:0] Q60_ONE = 64'd1 << 60;
    localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
    localparam logic [63:0] PI_STEP = PI_Q60 / HALF_CIRCLE;
    localparam logic [63:0] PI_FRAC = PI_Q60 % HALF_CIRCLE;

    // round(32767 * cos(2*pi*k/FFT_MAX)) for k = 0..QUARTER, integer Taylor
    // series in Q60, evaluated at elaboration
    function automatic rom_t build_cos_rom();
        rom_t         rom;
        logic [63:0]  x;
        logic [63:0]  term;
        logic [63:0]  sum;
        logic [63:0]  v;
        logic [127:0] prod;
        for (int k = 0; k <= QUARTER; k++)
        begin
            x    = PI_STEP * 64'(k) + (PI_FRAC * 64'(k)) / HALF_CIRCLE;
            term = Q60_ONE;
            sum  = Q60_ONE;
            for (int i = 1; i <= 36; i++)
            begin
                prod = {64'd0, term} * {64'd0, x};
                term = prod[123:60] / 64'(i);
                if ((i & 3) == 2)
                begin
                    sum = sum - term;
                end
                else if ((i & 3) == 0)
                begin
                    sum = sum + term;
                end
            end
            if (sum[63])
            begin
                sum = 64'd0;
            end
            v = (sum >> 20) * 64'd32767;
            v = (v + (64'd1 << 39)) >> 40;
            if (v > 64'd32767)
            begin
                v = 64'd32767;
            end
            rom[k] = v[15:0];
        end
        return rom;
    endfunction

    localparam rom_t COS_ROM = build_cos_rom();

endpackage

// ----- hdl/tophr_regs.sv -----
// Configuration registers behind the APB port, and the effective values
// derived from them. Depends on tophr_pkg.
`timescale 1ns / 1ps

module tophr_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tophr_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output tophr_pkg::cfg_t               cfg
);
    import tophr_pkg::*;

    logic [3:0]  fft_log2_reg;
    logic [9:0]  cp_span_reg;
    logic [12:0] sc_count_reg;

    logic        wr_en;
    logic [1:0]  reg_idx;
    logic [3:0]  log2_eff;
    logic [12:0] n_eff;
    logic [12:0] count_eff;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fft_log2_reg <= 4'(FFT_LOG2_RESET);
            cp_span_reg  <= 10'(CP_SPAN_RESET);
            sc_count_reg <= 13'(SC_COUNT_RESET);
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_FFT_LOG2: fft_log2_reg <= pwdata[3:0];
                REG_CP_SPAN:  cp_span_reg  <= pwdata[9:0];
                REG_SC_COUNT: sc_count_reg <= pwdata[12:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_FFT_LOG2: prdata = {28'd0, fft_log2_reg};
            REG_CP_SPAN:  prdata = {22'd0, cp_span_reg};
            REG_SC_COUNT: prdata = {19'd0, sc_count_reg};
            default:      prdata = 32'd0;
        endcase
    end

    // Saturate log2(N) and the subcarrier count into their legal ranges
    always_comb
    begin
        if (fft_log2_reg < 4'(LOG2_MIN))
        begin
            log2_eff = 4'(LOG2_MIN);
        end
        else if (fft_log2_reg > 4'(LOG2_MAX))
        begin
            log2_eff = 4'(LOG2_MAX);
        end
        else
        begin
            log2_eff = fft_log2_reg;
        end
        n_eff = 13'd1 << log2_eff;
        if (sc_count_reg == 13'd0)
        begin
            count_eff = 13'd1;
        end
        else if (sc_count_reg > n_eff)
        begin
            count_eff = n_eff;
        end
        else
        begin
            count_eff = sc_count_reg;
        end
    end

    assign cfg.cp_span    = cp_span_reg;
    assign cfg.count      = count_eff;
    assign cfg.neg_half   = PH_W'(0) - PH_W'(count_eff >> 1);
    assign cfg.phase_mask = PH_W'(n_eff - 13'd1);
    assign cfg.idx_shift  = 3'(4'(LOG2_MAX) - log2_eff);

endmodule

// ----- hdl/tophr_front.sv -----
// Front end: accepts restart words, walks offset/subcarrier/phase state and
// pushes one classified entry per accepted word. Depends on tophr_pkg.
`timescale 1ns / 1ps

module tophr_front (
    input  logic              clk,
    input  logic              rst_n,
    input  tophr_pkg::cfg_t   cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              restart,
    output logic              push,
    output tophr_pkg::entry_t push_entry,
    input  logic              q_full
);
    import tophr_pkg::*;

    logic signed [10:0] offset_reg, offset_next;
    logic [11:0]        subcarrier_reg, subcarrier_next;
    logic [PH_W-1:0]    phase_reg, phase_next;

    logic signed [10:0] neg_cp;
    logic signed [10:0] cur_off;
    logic [11:0]        cur_sc;
    logic [PH_W-1:0]    cur_ph;
    logic [2*PH_W-1:0]  prod_cp;
    logic [2*PH_W-1:0]  prod_off;
    logic [PH_W-1:0]    rs_neg_cp;
    logic [PH_W-1:0]    rs_cur;
    logic               last_sc;
    logic               last_row;

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;

    assign neg_cp = 11'(0) - $signed({1'b0, cfg.cp_span});

    // Row start phase is neg_half * t mod N; two multipliers cover t = -cp
    // and t = current offset
    assign prod_cp   = cfg.neg_half * PH_W'(neg_cp);
    assign prod_off  = cfg.neg_half * PH_W'(offset_reg);
    assign rs_neg_cp = prod_cp[PH_W-1:0];
    assign rs_cur    = restart ? rs_neg_cp : prod_off[PH_W-1:0];

    assign cur_off = restart ? neg_cp : offset_reg;
    assign cur_sc  = restart ? 12'd0 : subcarrier_reg;
    assign cur_ph  = restart ? rs_neg_cp : phase_reg;

    assign last_sc  = ({1'b0, cur_sc} + 13'd1) >= cfg.count;
    assign last_row = cur_off >= $signed({1'b0, cfg.cp_span});

    always_comb
    begin
        if (!last_sc)
        begin
            subcarrier_next = cur_sc + 12'd1;
            offset_next     = cur_off;
            phase_next      = cur_ph + PH_W'(cur_off);
        end
        else if (last_row)
        begin
            subcarrier_next = 12'd0;
            offset_next     = neg_cp;
            phase_next      = rs_neg_cp;
        end
        else
        begin
            subcarrier_next = 12'd0;
            offset_next     = cur_off + 11'sd1;
            phase_next      = rs_cur + cfg.neg_half;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg     <= OFFSET_RESET;
            subcarrier_reg <= 12'd0;
            phase_reg      <= PHASE_RESET;
        end
        else if (push)
        begin
            offset_reg     <= offset_next;
            subcarrier_reg <= subcarrier_next;
            phase_reg      <= phase_next;
        end
    end

    assign push_entry.phase      = cur_ph;
    assign push_entry.offset     = cur_off;
    assign push_entry.subcarrier = cur_sc;
    assign push_entry.table_end  = last_sc && last_row;

endmodule

// ----- hdl/tophr_queue.sv -----
// Short flop FIFO of classified entries between front and back.
// Depends on tophr_pkg.
`timescale 1ns / 1ps

module tophr_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tophr_pkg::entry_t push_entry,
    output logic              full,
    input  logic              pop,
    output tophr_pkg::entry_t head,
    output logic              empty
);
    import tophr_pkg::*;

    entry_t              mem [0:QDEPTH-1];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;

    assign full  = count_reg == QCNT_W'(QDEPTH);
    assign empty = count_reg == '0;
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0
                                                                : wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0
                                                                : rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

// ----- hdl/tophr_back.sv -----
// Back end: scales the phase to a ROM index, reads the quarter-wave ROM and
// folds the quadrant into the output register. Depends on tophr_pkg.
`timescale 1ns / 1ps

module tophr_back (
    input  logic                clk,
    input  logic                rst_n,
    input  tophr_pkg::cfg_t     cfg,
    input  tophr_pkg::entry_t   head,
    input  logic                empty,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [15:0]  cos_q15,
    output logic signed [15:0]  sin_q15,
    output logic signed [10:0]  offset_now,
    output logic [11:0]         subcarrier_now,
    output logic                table_end
);
    import tophr_pkg::*;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    logic [PH_W-1:0]    idx;
    logic [RA_W-1:0]    addr_a, addr_b;

    // ROM read stage
    logic               rd_valid_reg;
    logic [15:0]        rom_a_reg, rom_b_reg;
    logic [1:0]         quad_reg;
    logic signed [10:0] rd_off_reg;
    logic [11:0]        rd_sc_reg;
    logic               rd_end_reg;

    // Output stage
    logic               out_valid_reg;
    logic signed [15:0] cos_reg, sin_reg, cos_next, sin_next;
    logic signed [10:0] off_reg;
    logic [11:0]        sc_reg;
    logic               end_reg;

    logic               adv_rd;

    assign idx    = PH_W'((head.phase & cfg.phase_mask) << cfg.idx_shift);
    assign addr_a = {1'b0, idx[PH_W-3:0]};
    assign addr_b = RA_W'(QUARTER) - addr_a;

    assign adv_rd = rd_valid_reg && (!out_valid_reg || out_ready);
    assign pop    = !empty && (!rd_valid_reg || adv_rd);

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rom_a_reg  <= COS_ROM[addr_a];
            rom_b_reg  <= COS_ROM[addr_b];
            quad_reg   <= idx[PH_W-1 -: 2];
            rd_off_reg <= head.offset;
            rd_sc_reg  <= head.subcarrier;
            rd_end_reg <= head.table_end;
        end
    end

    always_comb
    begin
        case (quad_reg)
            QUAD_0:
            begin
                cos_next = $signed(rom_a_reg);
                sin_next = $signed(rom_b_reg);
            end
            QUAD_1:
            begin
                cos_next = -$signed(rom_b_reg);
                sin_next = $signed(rom_a_reg);
            end
            QUAD_2:
            begin
                cos_next = -$signed(rom_a_reg);
                sin_next = -$signed(rom_b_reg);
            end
            QUAD_3:
            begin
                cos_next = $signed(rom_b_reg);
                sin_next = -$signed(rom_a_reg);
            end
            default:
            begin
                cos_next = $signed(rom_a_reg);
                sin_next = $signed(rom_b_reg);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv_rd)
        begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
            off_reg <= rd_off_reg;
            sc_reg  <= rd_sc_reg;
            end_reg <= rd_end_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                rd_valid_reg <= 1'b1;
            end
            else if (adv_rd)
            begin
                rd_valid_reg <= 1'b0;
            end
            if (adv_rd)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign cos_q15        = cos_reg;
    assign sin_q15        = sin_reg;
    assign offset_now     = off_reg;
    assign subcarrier_now = sc_reg;
    assign table_end      = end_reg;

endmodule

// ----- hdl/time_offset_phase_ramp_generator.sv -----
// Top level of the time-offset phase ramp generator: APB registers, front
// end, entry FIFO and ROM back end. Depends on tophr_pkg and all tophr_ modules.
`timescale 1ns / 1ps

// Usage
//   Each word accepted on the s_axis channel asks for one table entry:
//   s_axis_tdata[0] = restart rewinds to offset -cp_span, subcarrier 0 and
//   emits that entry; 0 emits the current entry and advances. The entry
//   comes out as one word on m_axis with cos/sin in Q1.15, the offset and
//   the subcarrier; m_axis_tlast flags the final entry of the whole table,
//   after which the walk wraps to the first entry.
//   Throughput is one word per clock while m_axis_tready stays high. The
//   entry is written into the FIFO at the accepting edge, then read from
//   the ROM into a register, then folded by quadrant into the output
//   register that drives m_axis_tvalid.
//   When the receiver stalls, the output register and the ROM stage hold
//   and the 4-entry FIFO fills; s_axis_tready drops only once it is full.
//   Reset loads fft_log2 = 12, cp_span = 288, sc_count = 3276 and places the
//   walk at its first entry; no clearing pass is needed.
//   Write the APB registers only while no word is in flight.

module time_offset_phase_ramp_generator (
    input  logic                          clk,
    input  logic                          rst_n,
    // APB configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tophr_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // Request stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // [0] restart, [7:1] zero
    // Entry stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [55:0]                   m_axis_tdata,  // [15:0] cos_q15, [31:16] sin_q15,
                                                         // [42:32] offset_now,
                                                         // [54:43] subcarrier_now, [55] zero
    output logic                          m_axis_tlast   // table_end
);
    import tophr_pkg::*;

    cfg_t               cfg;
    logic               push;
    entry_t             push_entry;
    logic               q_full;
    logic               pop;
    entry_t             head;
    logic               q_empty;
    logic signed [15:0] cos_q15;
    logic signed [15:0] sin_q15;
    logic signed [10:0] offset_now;
    logic [11:0]        subcarrier_now;

    // Configuration registers and derived effective values
    tophr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Walk the table and classify each requested entry
    tophr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .restart    (s_axis_tdata[0]),
        .push       (push),
        .push_entry (push_entry),
        .q_full     (q_full)
    );

    // Decouple the walk from the ROM pipeline
    tophr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head       (head),
        .empty      (q_empty)
    );

    // Look up cos/sin and hold the result for the receiver
    tophr_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .head           (head),
        .empty          (q_empty),
        .pop            (pop),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .cos_q15        (cos_q15),
        .sin_q15        (sin_q15),
        .offset_now     (offset_now),
        .subcarrier_now (subcarrier_now),
        .table_end      (m_axis_tlast)
    );

    // Pack the entry word, first field lowest
    assign m_axis_tdata = {1'b0, subcarrier_now, offset_now, sin_q15, cos_q15};

endmodule

// ----- sim/tb_time_offset_phase_ramp_generator.sv -----
// Self-checking testbench for time_offset_phase_ramp_generator: APB setup,
// a request stream in, a table-entry stream out, compared against a local predictor.
// Depends on tophr_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_time_offset_phase_ramp_generator;

    import tophr_pkg::*;

    localparam int CLK_PERIOD  = 12;
    localparam int RESET_LEN   = 11;
    localparam int QUIET_LIMIT = 2000;   // cycles with no handshake at all before giving up
    localparam int DRAIN_WAIT  = 10;     // idle wait for stray words after the drain
    localparam int PRINT_CAP   = 50;
    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

    // One table entry as it leaves the block
    typedef struct packed {
        logic signed [15:0] cos_q15;
        logic signed [15:0] sin_q15;
        logic signed [10:0] offset;
        logic [11:0]        subcarrier;
        logic               table_end;
    } ramp_entry_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata;   // [0] restart, [7:1] zero
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [55:0]         m_axis_tdata;   // [15:0] cos, [31:16] sin, [42:32] offset,
                                         // [54:43] subcarrier, [55] zero
    logic                m_axis_tlast;   // table_end

    // Predictor copy of the registers and of the table walk
    int unsigned         cfg_log2;
    int unsigned         cfg_cp;
    int unsigned         cfg_sc;
    logic signed [10:0]  walk_offset;
    logic [11:0]         walk_sc;
    logic [11:0]         walk_phase;
    logic [15:0]         cos_quarter [0:QUARTER];

    ramp_entry_t         pending_entries [$];
    int                  mismatch_count;
    int                  quiet_cycles;
    int                  hold_request;   // long receiver hold-off, picked up by the sink
    bit                  gapless;        // both sides run without idling

    time_offset_phase_ramp_generator u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Quarter-wave cosine table: round(32767 * cos(2*pi*k/FFT_MAX)), built
    // from a Q60 Taylor series so that ties and near-ties round exactly.
    function automatic void fill_cos_quarter();
        logic [63:0]  x;
        logic [63:0]  term;
        logic [63:0]  sum;
        logic [63:0]  v;
        logic [127:0] prod;
        for (int k = 0; k <= QUARTER; k++)
        begin
            x = (PI_Q60 / 64'd2048) * 64'(k) + ((PI_Q60 % 64'd2048) * 64'(k)) / 64'd2048;
            term = 64'd1 << 60;
            sum  = 64'd1 << 60;
            for (int i = 1; i <= 36; i++)
            begin
                prod = {64'd0, term} * {64'd0, x};
                term = prod[123:60] / 64'(i);
                if (i % 4 == 2)
                begin
                    sum = sum - term;
                end
                else if (i % 4 == 0)
                begin
                    sum = sum + term;
                end
            end
            if (sum[63])
            begin
                sum = 64'd0;
            end
            v = (sum >> 20) * 64'd32767;
            v = (v + (64'd1 << 39)) >> 40;
            if (v > 64'd32767)
            begin
                v = 64'd32767;
            end
            cos_quarter[k] = v[15:0];
        end
    endfunction

    // FFT size exponent actually in force: saturated to 6..12
    function automatic int unsigned used_log2();
        int unsigned l;
        l = cfg_log2;
        if (l < LOG2_MIN)
        begin
            l = LOG2_MIN;
        end
        if (l > LOG2_MAX)
        begin
            l = LOG2_MAX;
        end
        return l;
    endfunction

    // Subcarriers per row: saturated to 1..N
    function automatic int unsigned used_count();
        int unsigned n;
        int unsigned c;
        n = 1 << used_log2();
        c = cfg_sc;
        if (c < 1)
        begin
            c = 1;
        end
        if (c > n)
        begin
            c = n;
        end
        return c;
    endfunction

    // Phase of subcarrier 0 in the row of offset t: (-(count/2) * t) mod 4096
    function automatic logic [11:0] row_phase(input logic signed [10:0] t);
        logic [11:0] neg_half;
        logic [11:0] t_wrapped;
        neg_half  = 12'(0 - (used_count() >> 1));
        t_wrapped = 12'(t);
        return 12'(neg_half * t_wrapped);
    endfunction

    function automatic void reset_walk();
        cfg_log2    = FFT_LOG2_RESET;
        cfg_cp      = CP_SPAN_RESET;
        cfg_sc      = SC_COUNT_RESET;
        walk_offset = 11'(-int'(cfg_cp));
        walk_sc     = '0;
        walk_phase  = row_phase(walk_offset);
    endfunction

    // Entry produced by one request word; advances the walk behind it
    function automatic ramp_entry_t ramp_predict(input bit restart);
        ramp_entry_t e;
        int unsigned l;
        int unsigned count;
        int unsigned idx;
        int unsigned r;
        int          a;
        int          b;
        int          c;
        int          s;
        bit          last_sc;
        bit          last_row;
        if (restart)
        begin
            walk_offset = 11'(-int'(cfg_cp));
            walk_sc     = '0;
            walk_phase  = row_phase(walk_offset);
        end
        l     = used_log2();
        count = used_count();
        idx   = (int'(walk_phase) & ((1 << l) - 1)) * (FFT_MAX >> l);
        r     = idx % QUARTER;
        a     = int'(cos_quarter[r]);
        b     = int'(cos_quarter[QUARTER - r]);
        // fold the quarter wave out to the full circle
        case ((idx / QUARTER) % 4)
            0:       begin c = a;  s = b;  end
            1:       begin c = -b; s = a;  end
            2:       begin c = -a; s = -b; end
            default: begin c = b;  s = -a; end
        endcase
        last_sc  = (int'(walk_sc) + 1) >= int'(count);
        last_row = int'(walk_offset) >= int'(cfg_cp);

        e.cos_q15    = 16'(c);
        e.sin_q15    = 16'(s);
        e.offset     = walk_offset;
        e.subcarrier = walk_sc;
        e.table_end  = last_sc && last_row;

        if (!last_sc)
        begin
            walk_sc    = walk_sc + 12'd1;
            walk_phase = walk_phase + 12'(walk_offset);
        end
        else
        begin
            walk_sc     = '0;
            walk_offset = last_row ? 11'(-int'(cfg_cp)) : walk_offset + 11'sd1;
            walk_phase  = row_phase(walk_offset);
        end
        return e;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report(input string what, input longint want, input longint got);
        if (mismatch_count < PRINT_CAP)
        begin
            $display("%0t mismatch %s: expected %0d, got %0d", $time, what, want, got);
        end
        mismatch_count++;
    endtask

    // Compare every accepted output word with the oldest pending entry
    always @(posedge clk)
    begin : entry_checker
        ramp_entry_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_entries.size() == 0)
            begin
                report("unexpected word, subcarrier", -1, m_axis_tdata[54:43]);
            end
            else
            begin
                want = pending_entries.pop_front();
                if (m_axis_tdata[15:0] !== want.cos_q15)
                begin
                    report("cos_q15", want.cos_q15, $signed(m_axis_tdata[15:0]));
                end
                if (m_axis_tdata[31:16] !== want.sin_q15)
                begin
                    report("sin_q15", want.sin_q15, $signed(m_axis_tdata[31:16]));
                end
                if (m_axis_tdata[42:32] !== want.offset)
                begin
                    report("offset_now", want.offset, $signed(m_axis_tdata[42:32]));
                end
                if (m_axis_tdata[54:43] !== want.subcarrier)
                begin
                    report("subcarrier_now", want.subcarrier, m_axis_tdata[54:43]);
                end
                if (m_axis_tlast !== want.table_end)
                begin
                    report("table_end", want.table_end, m_axis_tlast);
                end
            end
        end
    end

    // Watchdog: give up when no word, APB access or entry moves for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (psel && penable))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall before each word unless gapless, plus an
    // occasional long hold requested by a test and counted here.
    // ------------------------------------------------------------------
    initial
    begin : entry_sink
        int stall;
        m_axis_tready = 1'b0;
        forever
        begin
            stall = gapless ? 0 : $urandom_range(0, 19);
            if (hold_request > 0)
            begin
                stall        = hold_request;
                hold_request = 0;
            end
            @(negedge clk);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            // hold ready until a word goes through
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one request word after a random gap (none when gapless); record its entry once accepted.
    // tvalid stays high between back-to-back words.
    task automatic send_request(input bit restart);
        int gap;
        gap = gapless ? 0 : $urandom_range(0, 19);
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, restart};
        do @(posedge clk); while (!s_axis_tready);
        pending_entries.push_back(ramp_predict(restart));
    endtask

    // Drop the request stream and wait until every entry has come back
    task automatic settle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_entries.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (5) @(posedge clk);
    endtask

    // APB write, then read back the same register
    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] readback;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        readback = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== value)
        begin
            report($sformatf("readback of register %0d", idx), value, readback);
        end
    endtask

    // Reprogram all three registers while the block is idle
    task automatic set_config(input int unsigned log2, input int unsigned cp,
                              input int unsigned sc);
        settle();
        write_register(REG_FFT_LOG2, 32'(log2 & 'hF));
        write_register(REG_CP_SPAN, 32'(cp & 'h3FF));
        write_register(REG_SC_COUNT, 32'(sc & 'h1FFF));
        cfg_log2 = log2 & 'hF;
        cfg_cp   = cp & 'h3FF;
        cfg_sc   = sc & 'h1FFF;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Walk from the reset position without a restart, then rewind
    task automatic test_reset_state();
        repeat (3) send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
    endtask

    // Tiny table on the smallest FFT: the walk runs from one row into the
    // next; one restart in the middle of a row
    task automatic test_small_table();
        set_config(6, 1, 4);
        send_request(1'b1);
        repeat (5) send_request(1'b0);
        send_request(1'b1);
        repeat (6) send_request(1'b0);
    endtask

    // Register values beyond the usable range: exponent and count saturate,
    // widest offset span
    task automatic test_saturation();
        set_config(15, 1023, 8191);
        send_request(1'b1);
        repeat (2) send_request(1'b0);
    endtask

    // Zero exponent and zero count: one subcarrier per row, one row, so
    // every entry ends the table
    task automatic test_degenerate();
        set_config(0, 0, 0);
        send_request(1'b1);
        repeat (2) send_request(1'b0);
    endtask

    // Odd subcarrier count: the row start uses floor(count/2)
    task automatic test_odd_count();
        set_config(7, 2, 5);
        send_request(1'b1);
        repeat (3) send_request(1'b0);
    endtask

    // Hold the receiver off long enough that the entry FIFO fills and
    // s_axis_tready drops while requests keep coming
    task automatic test_backpressure();
        set_config(8, 2, 6);
        gapless      = 1'b1;
        hold_request = 80;
        send_request(1'b1);
        repeat (29) send_request(1'b0);
        gapless = 1'b0;
    endtask

    // Random configurations, each entered with a restart and then walked
    // with occasional restarts
    task automatic test_random_tables();
        int unsigned log2;
        int unsigned cp;
        int unsigned sc;
        for (int pass_idx = 0; pass_idx < 6; pass_idx++)
        begin
            log2 = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(6, 12);
            cp   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 6);
            sc   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 14);
            set_config(log2, cp, sc);
            gapless = ($urandom_range(0, 3) == 0);
            send_request(1'b1);
            repeat (49) send_request($urandom_range(0, 19) == 0);
        end
        gapless = 1'b0;
    endtask

    // One subcarrier per row over the widest span: offset starts at -1023
    // and steps one row per word
    task automatic test_full_offset_span();
        set_config(12, 1023, 0);
        gapless = 1'b1;
        send_request(1'b1);
        repeat (39) send_request(1'b0);
        gapless = 1'b0;
    endtask

    // Rows of 4096 subcarriers on the largest FFT: the count equals N and
    // the phase steps down by one per subcarrier
    task automatic test_full_subcarrier_row();
        set_config(12, 1, 4096);
        gapless = 1'b1;
        send_request(1'b1);
        repeat (49) send_request(1'b0);
        gapless = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        gapless        = 1'b0;
        hold_request   = 0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        fill_cos_quarter();
        reset_walk();

        repeat (RESET_LEN) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_small_table();
        test_saturation();
        test_degenerate();
        test_odd_count();
        test_backpressure();
        test_random_tables();
        test_full_offset_span();
        test_full_subcarrier_row();

        // let the last entries drain, then watch for stray words
        settle();
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/tophr_pkg.sv
hdl/tophr_regs.sv
hdl/tophr_front.sv
hdl/tophr_queue.sv
hdl/tophr_back.sv
hdl/time_offset_phase_ramp_generator.sv
sim/tb_time_offset_phase_ramp_generator.sv
